@@ rtl/lsmdf_pkg.sv @@
// shared constants and command/status types for the compaction drop filter
// no dependencies
package lsmdf_pkg;
	localparam int MAX_SNAPSHOTS  = 16;
	localparam int MAX_TOMBSTONES = 16;
	localparam int KEY_BITS = 64;
	localparam int SEQ_BITS = 56;
	localparam int SNAP_IDX_BITS = $clog2(MAX_SNAPSHOTS);
	localparam int SNAP_CNT_BITS = $clog2(MAX_SNAPSHOTS + 1);
	localparam int TOMB_IDX_BITS = $clog2(MAX_TOMBSTONES);
	localparam int TOMB_CNT_BITS = $clog2(MAX_TOMBSTONES + 1);

	localparam logic [1:0] MODE_BEGIN = 2'd0;
	localparam logic [1:0] MODE_SNAP  = 2'd1;
	localparam logic [1:0] MODE_TOMB  = 2'd2;
	localparam logic [1:0] MODE_ENTRY = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_ORDER = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CFG_BOTTOM = 1'b0;
	localparam logic CFG_PIN    = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input item
		logic quick;     // handle non-walking item (begin, snapshot, tombstone)
		logic walk_init; // start snapshot walk
		logic walk_step; // evaluate one snapshot
		logic finish;    // resolve entry result
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_walk;
		logic walk_done;
	} dp_sts_t;
endpackage

@@ rtl/lsmdf_datapath.sv @@
// tables, key state and snapshot walk datapath for the compaction drop filter
// depends on lsmdf_pkg
module lsmdf_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lsmdf_pkg::dp_cmd_t          cmd,
	output lsmdf_pkg::dp_sts_t          sts,
	input  logic [1:0]                  mode,
	input  logic [lsmdf_pkg::KEY_BITS-1:0] item_key,
	input  logic [lsmdf_pkg::KEY_BITS-1:0] range_end_key,
	input  logic                        range_end_open,
	input  logic [lsmdf_pkg::SEQ_BITS-1:0] sequence_req,
	input  logic                        is_deletion,
	input  logic                        bottom_lvl_q,
	input  logic [lsmdf_pkg::SEQ_BITS-1:0] pin_sequence_q,
	output logic                        keep,
	output logic                        key_boundary,
	output logic                        pin_forced,
	output logic [1:0]                  status
);
	import lsmdf_pkg::*;

	logic [SEQ_BITS-1:0] snap_mem [MAX_SNAPSHOTS];
	logic [KEY_BITS-1:0] ts_start [MAX_TOMBSTONES];
	logic [KEY_BITS-1:0] ts_end   [MAX_TOMBSTONES];
	logic                ts_open  [MAX_TOMBSTONES];
	logic [SEQ_BITS-1:0] ts_seq   [MAX_TOMBSTONES];
	logic [SNAP_CNT_BITS-1:0] snap_cnt_q;
	logic [TOMB_CNT_BITS-1:0] tomb_cnt_q;
	logic [KEY_BITS-1:0] cur_key_q;
	logic                key_seen_q;
	logic [SEQ_BITS:0]   newer_q;
	logic                pin_done_q;

	logic [1:0]          mode_q;
	logic [KEY_BITS-1:0] key_q;
	logic [KEY_BITS-1:0] end_q;
	logic                open_q;
	logic [SEQ_BITS-1:0] seq_q;
	logic                del_q;

	logic [SNAP_CNT_BITS-1:0] walk_q;
	logic                found_q;
	logic                stop_q;
	logic [SEQ_BITS:0]   eff_newer_q;
	logic                boundary_q;

	logic snap_below;
	logic [SEQ_BITS-1:0] s_cur;
	logic [MAX_TOMBSTONES-1:0] hides;
	logic walk_end;
	logic pin_hit;

	assign snap_below = (snap_cnt_q != '0) && (snap_mem[0] < seq_q);
	assign walk_end   = stop_q || (walk_q >= snap_cnt_q);
	assign s_cur      = snap_mem[walk_q[SNAP_IDX_BITS-1:0]];
	assign pin_hit    = (seq_q == pin_sequence_q);

	// tombstone visible at s_cur, covering key, newer than entry
	always_comb begin
		for (int i = 0; i < MAX_TOMBSTONES; i++) begin
			hides[i] = (TOMB_CNT_BITS'(i) < tomb_cnt_q) && (ts_seq[i] <= s_cur)
				&& (ts_seq[i] > seq_q) && (key_q >= ts_start[i])
				&& (ts_open[i] || key_q < ts_end[i]);
		end
	end

	// every entry, deletion or value, goes through the walk and finish steps
	assign sts.need_walk = (mode_q == MODE_ENTRY);
	assign sts.walk_done = walk_end;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			key_q  <= item_key;
			end_q  <= range_end_key;
			open_q <= range_end_open;
			seq_q  <= sequence_req;
			del_q  <= is_deletion;
		end
		if (cmd.quick && mode_q == MODE_SNAP && snap_cnt_q < SNAP_CNT_BITS'(MAX_SNAPSHOTS)
			&& !(snap_cnt_q != '0
				&& snap_mem[SNAP_IDX_BITS'(snap_cnt_q - 1'b1)] >= seq_q))
			snap_mem[snap_cnt_q[SNAP_IDX_BITS-1:0]] <= seq_q;
		if (cmd.quick && mode_q == MODE_TOMB && tomb_cnt_q < TOMB_CNT_BITS'(MAX_TOMBSTONES)) begin
			ts_start[tomb_cnt_q[TOMB_IDX_BITS-1:0]] <= key_q;
			ts_end[tomb_cnt_q[TOMB_IDX_BITS-1:0]]   <= end_q;
			ts_open[tomb_cnt_q[TOMB_IDX_BITS-1:0]]  <= open_q;
			ts_seq[tomb_cnt_q[TOMB_IDX_BITS-1:0]]   <= seq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_cnt_q <= '0;
			tomb_cnt_q <= '0;
			cur_key_q <= '0;
			key_seen_q <= 1'b0;
			newer_q <= {1'b1, {SEQ_BITS{1'b0}}};
			pin_done_q <= 1'b0;
			walk_q <= '0;
			found_q <= 1'b0;
			stop_q <= 1'b0;
			eff_newer_q <= '0;
			boundary_q <= 1'b0;
			keep <= 1'b0;
			key_boundary <= 1'b0;
			pin_forced <= 1'b0;
			status <= ST_OK;
		end else begin
			if (cmd.quick) begin
				key_boundary <= 1'b0;
				pin_forced <= 1'b0;
				case (mode_q)
					MODE_BEGIN: begin
						keep <= 1'b0;
						status <= ST_OK;
						snap_cnt_q <= '0;
						tomb_cnt_q <= '0;
						cur_key_q <= '0;
						key_seen_q <= 1'b0;
						newer_q <= {1'b1, {SEQ_BITS{1'b0}}};
						pin_done_q <= 1'b0;
					end
					MODE_SNAP: begin
						keep <= 1'b0;
						if (snap_cnt_q >= SNAP_CNT_BITS'(MAX_SNAPSHOTS))
							status <= ST_FULL;
						else if (snap_cnt_q != '0
							&& snap_mem[SNAP_IDX_BITS'(snap_cnt_q - 1'b1)] >= seq_q)
							status <= ST_ORDER;
						else begin
							status <= ST_OK;
							snap_cnt_q <= snap_cnt_q + 1'b1;
						end
					end
					MODE_TOMB: begin
						if (tomb_cnt_q >= TOMB_CNT_BITS'(MAX_TOMBSTONES)) begin
							status <= ST_FULL;
							keep <= 1'b0;
						end else begin
							status <= ST_OK;
							tomb_cnt_q <= tomb_cnt_q + 1'b1;
							keep <= !bottom_lvl_q || snap_below;
						end
					end
					default: begin
						keep <= 1'b0;
						status <= ST_OK;
					end
				endcase
			end
			if (cmd.walk_init) begin
				walk_q <= '0;
				if (!key_seen_q || cur_key_q != key_q) begin
					eff_newer_q <= {1'b1, {SEQ_BITS{1'b0}}};
					boundary_q <= 1'b1;
				end else begin
					eff_newer_q <= newer_q;
					boundary_q <= newer_q[SEQ_BITS];
				end
				// deletion verdict is known at once
				found_q <= del_q && (!bottom_lvl_q || snap_below);
				stop_q <= del_q;
			end
			if (cmd.walk_step && !walk_end) begin
				walk_q <= walk_q + 1'b1;
				if (s_cur >= seq_q) begin
					if ({1'b0, s_cur} >= eff_newer_q)
						stop_q <= 1'b1;
					else if (hides == '0) begin
						found_q <= 1'b1;
						stop_q <= 1'b1;
					end
				end
			end
			if (cmd.finish) begin
				cur_key_q <= key_q;
				key_seen_q <= 1'b1;
				newer_q <= {1'b0, seq_q};
				key_boundary <= boundary_q;
				status <= ST_OK;
				keep <= found_q || (pin_hit && !pin_done_q);
				pin_forced <= pin_hit && !found_q && !pin_done_q;
				if (pin_hit && (found_q || !pin_done_q))
					pin_done_q <= 1'b1;
			end
		end
	end
endmodule

@@ rtl/lsmdf_ctrl.sv @@
// controller state machine for the compaction drop filter
// depends on lsmdf_pkg
module lsmdf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output lsmdf_pkg::dp_cmd_t cmd,
	input  lsmdf_pkg::dp_sts_t sts
);
	import lsmdf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_FIN  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0] state_q;

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && start;
		case (state_q)
			S_DISP: begin
				cmd.quick = !sts.need_walk;
				cmd.walk_init = sts.need_walk || 1'b0;
			end
			S_WALK: cmd.walk_step = 1'b1;
			S_FIN:  cmd.finish = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) state_q <= S_DISP;
				S_DISP: state_q <= sts.need_walk ? S_WALK : S_OUT;
				S_WALK: if (sts.walk_done) state_q <= S_FIN;
				S_FIN:  state_q <= S_OUT;
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/lsm_compaction_drop_filter.sv @@
// LSM compaction keep-or-drop filter: command-style item port, one result each.
// Start is taken while busy is low; mode selects begin, snapshot, tombstone or
// entry. Each item gives exactly one result on keep, key_boundary, pin_forced
// and status, marked by done for one cycle; the receiver cannot stall it.
// Begin, snapshot and tombstone items pass the dispatch and output states;
// entries pass dispatch, walk, finish and output, and a point deletion's walk
// ends at once. A value entry walks the snapshot table one snapshot a cycle,
// each step comparing all stored tombstones at once, and the walk ends early
// at the first snapshot that keeps the entry or reaches the next-newer
// version. Busy drops in the done cycle, so the next start can be taken at
// the edge that takes the result; a new item is not taken before the last
// one's result is given. Configuration (bottom-level flag index 0,
// pin_sequence index 1) is written through cfg_we / cfg_index / cfg_data;
// the user must write it only while idle, which the block does not enforce.
// Reset clears counts, key state and configuration; table contents are
// undefined until loaded after a begin or reset.
// depends on lsmdf_pkg, lsmdf_ctrl, lsmdf_datapath
module lsm_compaction_drop_filter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	output logic                            done,
	input  logic [1:0]                      mode,
	input  logic [lsmdf_pkg::KEY_BITS-1:0]  item_key,
	input  logic [lsmdf_pkg::KEY_BITS-1:0]  range_end_key,
	input  logic                            range_end_open,
	input  logic [lsmdf_pkg::SEQ_BITS-1:0]  sequence_req,
	input  logic                            is_deletion,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [lsmdf_pkg::SEQ_BITS-1:0]  cfg_data,
	output logic                            keep,
	output logic                            key_boundary,
	output logic                            pin_forced,
	output logic [1:0]                      status
);
	import lsmdf_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic bottom_lvl_q;
	logic [SEQ_BITS-1:0] pin_sequence_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_lvl_q <= 1'b0;
			pin_sequence_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BOTTOM)
				bottom_lvl_q <= cfg_data[0];
			else
				pin_sequence_q <= cfg_data;
		end
	end

	lsmdf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .sts(sts)
	);

	lsmdf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .mode(mode),
		.item_key(item_key), .range_end_key(range_end_key),
		.range_end_open(range_end_open), .sequence_req(sequence_req),
		.is_deletion(is_deletion), .bottom_lvl_q(bottom_lvl_q),
		.pin_sequence_q(pin_sequence_q), .keep(keep), .key_boundary(key_boundary),
		.pin_forced(pin_forced), .status(status)
	);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("accepted item did not raise busy");
	a_pin_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(done && pin_forced) |-> keep) else $error("forced entry not kept");
	a_status_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(done && key_boundary) |-> status == ST_OK) else $error("entry with error status");
endmodule

@@ tb/sv/lsm_compaction_drop_filter_tb.sv @@
// self-checking bench for the compaction drop filter: random and directed beats
// are checked against an in-bench predictor of the keep-or-drop rules
// depends on lsmdf_pkg and lsm_compaction_drop_filter
module lsm_compaction_drop_filter_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lsmdf_pkg::*;

	typedef logic [KEY_BITS-1:0] key_t;
	typedef logic [SEQ_BITS-1:0] seq_t;

	typedef struct {
		logic [1:0] mode;
		key_t       key;
		key_t       end_key;
		logic       end_open;
		seq_t       seq;
		logic       deletion;
	} filt_item_t;

	typedef struct {
		logic       keep;
		logic       boundary;
		logic       forced;
		logic [1:0] status;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy, done;
	logic [1:0] mode = MODE_BEGIN;
	key_t item_key = '0;
	key_t range_end_key = '0;
	logic range_end_open = 0;
	seq_t sequence_req = '0;
	logic is_deletion = 0;
	logic cfg_we = 0;
	logic cfg_index = CFG_BOTTOM;
	seq_t cfg_data = '0;
	logic keep, key_boundary, pin_forced;
	logic [1:0] status;

	lsm_compaction_drop_filter dut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// predictor state
	logic pm_bottom;
	seq_t pm_pin;
	seq_t snaps [MAX_SNAPSHOTS];
	int   snap_n;
	key_t t_start [MAX_TOMBSTONES];
	key_t t_end [MAX_TOMBSTONES];
	logic t_open [MAX_TOMBSTONES];
	seq_t t_seq [MAX_TOMBSTONES];
	int   tomb_n;
	key_t cur_key;
	logic key_seen;
	logic [SEQ_BITS:0] newer_ver;
	logic pin_done;

	filt_item_t pending_items[$];
	verdict_t   expected_verdicts[$];
	int errors = 0;
	int idle_pct = 24;
	int stall_cycles = 0;
	bit stim_done = 0;

	function automatic void add_item(filt_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic void clear_run();
		snap_n = 0;
		tomb_n = 0;
		cur_key = '0;
		key_seen = 0;
		newer_ver = {1'b1, {SEQ_BITS{1'b0}}};
		pin_done = 0;
	endfunction

	function automatic logic snap_below(seq_t q);
		return snap_n > 0 && snaps[0] < q;
	endfunction

	function automatic seq_t newest_cover(key_t k, seq_t at);
		seq_t best = '0;
		for (int i = 0; i < tomb_n; i++) begin
			if (t_seq[i] > at || t_seq[i] <= best) continue;
			if (k >= t_start[i] && (t_open[i] || k < t_end[i])) best = t_seq[i];
		end
		return best;
	endfunction

	function automatic verdict_t predict_verdict(filt_item_t it);
		verdict_t v = '{0, 0, 0, ST_OK};
		logic k = 0;
		case (it.mode)
			MODE_BEGIN: clear_run();
			MODE_SNAP: begin
				if (snap_n >= MAX_SNAPSHOTS) v.status = ST_FULL;
				else if (snap_n > 0 && snaps[snap_n-1] >= it.seq) v.status = ST_ORDER;
				else begin
					snaps[snap_n] = it.seq;
					snap_n++;
				end
			end
			MODE_TOMB: begin
				if (tomb_n >= MAX_TOMBSTONES) v.status = ST_FULL;
				else begin
					t_start[tomb_n] = it.key;
					t_end[tomb_n] = it.end_key;
					t_open[tomb_n] = it.end_open;
					t_seq[tomb_n] = it.seq;
					tomb_n++;
					v.keep = !pm_bottom || snap_below(it.seq);
				end
			end
			default: begin
				if (!key_seen || cur_key != it.key) begin
					cur_key = it.key;
					key_seen = 1;
					newer_ver = {1'b1, {SEQ_BITS{1'b0}}};
				end
				if (!it.deletion) begin
					for (int i = 0; i < snap_n; i++) begin
						if (snaps[i] < it.seq) continue;
						if ({1'b0, snaps[i]} >= newer_ver) break;
						if (newest_cover(it.key, snaps[i]) > it.seq) continue;
						k = 1;
						break;
					end
				end else k = !pm_bottom || snap_below(it.seq);
				if (it.seq == pm_pin) begin
					if (!k && !pin_done) begin
						k = 1;
						v.forced = 1;
					end
					if (k) pin_done = 1;
				end
				v.boundary = newer_ver[SEQ_BITS];
				v.keep = k;
				newer_ver = {1'b0, it.seq};
			end
		endcase
		return v;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_verdicts.insert(expected_verdicts.size(),
					predict_verdict(pending_items.pop_front()));
			end
			if (pending_items.size() > 0 && !($urandom_range(99) < idle_pct)) begin
				start <= 1;
				mode <= pending_items[0].mode;
				item_key <= pending_items[0].key;
				range_end_key <= pending_items[0].end_key;
				range_end_open <= pending_items[0].end_open;
				sequence_req <= pending_items[0].seq;
				is_deletion <= pending_items[0].deletion;
			end else start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		verdict_t e;
		if (done) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: unexpected beat keep=%0d bnd=%0d pin=%0d st=%0d", $realtime,
					keep, key_boundary, pin_forced, status);
				errors++;
			end else begin
				e = expected_verdicts.pop_front();
				if (e.keep !== keep || e.boundary !== key_boundary
					|| e.forced !== pin_forced || e.status !== status) begin
					$display("%0t: expected keep=%0d bnd=%0d pin=%0d st=%0d, got %0d %0d %0d %0d",
						$realtime, e.keep, e.boundary, e.forced, e.status,
						keep, key_boundary, pin_forced, status);
					errors++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n || stim_done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles > 5000) begin
			$display("Mismatches found");
			$finish;
		end
	end

	function automatic filt_item_t mk(logic [1:0] m, key_t k, key_t e, logic o, seq_t s,
		logic d);
		filt_item_t it;
		it.mode = m; it.key = k; it.end_key = e; it.end_open = o;
		it.seq = s; it.deletion = d;
		return it;
	endfunction

	function automatic key_t rkey();
		return {$urandom, $urandom};
	endfunction

	function automatic seq_t rseq();
		return seq_t'({$urandom, $urandom});
	endfunction

	function automatic logic rbit();
		return 1'($urandom);
	endfunction

	task automatic drain();
		while (pending_items.size() > 0 || expected_verdicts.size() > 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_cfg(logic idx, seq_t val);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		pm_bottom = (idx == CFG_BOTTOM) ? val[0] : pm_bottom;
		pm_pin = (idx == CFG_PIN) ? val : pm_pin;
	endtask

	// one compaction run: snapshots, tombstones, then merged entries in a small key space
	task automatic queue_run(int n_entries, logic small_space);
		seq_t s = '0;
		key_t base = small_space ? key_t'($urandom_range(1000)) : rkey();
		key_t k;
		seq_t es;
		add_item(mk(MODE_BEGIN, rkey(), rkey(), rbit(), rseq(), rbit()));
		repeat ($urandom_range(18)) begin
			if ($urandom_range(9) == 0) s = s - seq_t'($urandom_range(3));
			else s = s + seq_t'($urandom_range(small_space ? 20 : 1 << 30));
			add_item(mk(MODE_SNAP, rkey(), rkey(), rbit(), s, rbit()));
		end
		repeat ($urandom_range(18)) begin
			k = base + key_t'($urandom_range(40));
			add_item(mk(MODE_TOMB, k, k + key_t'($urandom_range(30)) - 5,
				$urandom_range(5) == 0, seq_t'($urandom_range(small_space ? 300 : 1 << 30)),
				rbit()));
		end
		k = base;
		es = seq_t'($urandom_range(300));
		for (int i = 0; i < n_entries; i++) begin
			if ($urandom_range(2) == 0) begin
				k = k + key_t'($urandom_range(1, 3));
				es = seq_t'($urandom_range(300));
			end else es = (es > 20) ? es - seq_t'($urandom_range(1, 20)) : es;
			if ($urandom_range(15) == 0) es = pm_pin;
			add_item(mk(MODE_ENTRY, k, '0, 1'b0, es, $urandom_range(4) == 0));
		end
	endtask

	initial begin
		int total;
		pm_bottom = 0;
		pm_pin = '0;
		clear_run();
		repeat (11) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, every mode, table full and order errors
		write_cfg(CFG_BOTTOM, seq_t'(1));
		write_cfg(CFG_PIN, seq_t'(5));
		add_item(mk(MODE_BEGIN, '1, '1, 1, '1, 1));
		add_item(mk(MODE_TOMB, '0, '1, 0, '1, 0));
		add_item(mk(MODE_SNAP, '1, '0, 1, seq_t'(3), 1));
		add_item(mk(MODE_SNAP, '0, '0, 0, seq_t'(3), 0));
		add_item(mk(MODE_SNAP, '0, '0, 0, '1, 0));
		add_item(mk(MODE_TOMB, key_t'(10), key_t'(5), 0, seq_t'(9), 0));
		add_item(mk(MODE_TOMB, key_t'(10), '0, 1, seq_t'(2), 1));
		add_item(mk(MODE_ENTRY, '1, '1, 1, '1, 0));
		add_item(mk(MODE_ENTRY, '1, '0, 0, seq_t'(5), 0));
		add_item(mk(MODE_ENTRY, '1, '0, 0, seq_t'(2), 1));
		add_item(mk(MODE_ENTRY, '0, '0, 0, '0, 0));
		add_item(mk(MODE_ENTRY, key_t'(12), '0, 0, seq_t'(1), 0));
		for (int i = 0; i < 17; i++)
			add_item(mk(MODE_TOMB, key_t'(i), key_t'(i + 1), 0, seq_t'(i), 0));
		drain();
		write_cfg(CFG_BOTTOM, seq_t'(0));
		write_cfg(CFG_PIN, '1);
		add_item(mk(MODE_BEGIN, '0, '0, 0, '0, 0));
		for (int i = 0; i < 17; i++)
			add_item(mk(MODE_SNAP, '0, '0, 0, seq_t'(i * 7), 0));
		add_item(mk(MODE_ENTRY, key_t'(4), '0, 0, '1, 0));
		add_item(mk(MODE_ENTRY, key_t'(4), '0, 0, seq_t'(3), 0));
		drain();

		// random runs with configuration changes between phases
		total = 0;
		for (int ph = 0; total < 1650; ph++) begin
			idle_pct = (ph % 5 == 2) ? 0 : 24;
			write_cfg(CFG_BOTTOM, seq_t'($urandom_range(1)));
			write_cfg(CFG_PIN, (ph % 7 == 6) ? rseq() : seq_t'($urandom_range(300)));
			repeat (4) begin
				queue_run($urandom_range(10, 40), $urandom_range(5) != 0);
				total += pending_items.size();
				drain();
			end
		end
		stim_done = 1;
		repeat (30) @(posedge clk);
		if (errors == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule

@@ files.f @@
rtl/lsmdf_pkg.sv
rtl/lsmdf_datapath.sv
rtl/lsmdf_ctrl.sv
rtl/lsm_compaction_drop_filter.sv
tb/sv/lsm_compaction_drop_filter_tb.sv
